// File: hdl/mlf_pkg.sv
// Package for the MAC learning forwarder: widths, constants, learn codes and the
// request record that travels along the cell chain. No dependencies.
`timescale 1ns / 1ps

package mlf_pkg;

	localparam int MAC_W         = 48;
	localparam int PORT_W        = 3;
	localparam int CFG_W         = 4;
	localparam int MASK_W        = 8;
	localparam int GROUP_BIT     = 40;
	localparam int MAX_PORTS     = 8;
	localparam int TABLE_DEFAULT = 64;
	localparam logic [CFG_W-1:0] PORTS_RESET = CFG_W'(8);
	localparam logic [CFG_W-1:0] PORTS_LIMIT =
		CFG_W'((MAX_PORTS < MASK_W) ? MAX_PORTS : MASK_W);

	typedef enum logic [1:0] {
		LRN_NONE     = 2'd0,
		LRN_UPDATED  = 2'd1,
		LRN_INSERTED = 2'd2,
		LRN_FULL     = 2'd3
	} lrn_status_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] ingress_port;
		logic              long_enough;
		logic              learned;
		logic              hit;
		logic [PORT_W-1:0] hit_port;
		lrn_status_t       status;
	} req_t;

endpackage

// File: hdl/mlf_cell.sv
// One table cell: holds one MAC entry, learns and looks up for the request
// passing through, and registers the request for the next cell. Uses mlf_pkg.
`timescale 1ns / 1ps

module mlf_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  mlf_pkg::req_t req_in,
	output mlf_pkg::req_t req_out
);
	import mlf_pkg::*;

	logic              valid_q;
	logic [MAC_W-1:0]  addr_q;
	logic [PORT_W-1:0] port_q;
	req_t              req_s1;

	logic              learn_act;
	logic              upd;
	logic              ins;
	logic              eff_valid;
	logic [MAC_W-1:0]  eff_addr;
	logic [PORT_W-1:0] eff_port;
	logic              hit_here;
	req_t              req_nxt;

	// Entries fill from the front of the chain and are never removed, so the
	// first empty cell a request meets means the address is nowhere further on.
	always_comb begin
		learn_act = req_in.valid & req_in.long_enough & ~req_in.src_mac[GROUP_BIT]
			& ~req_in.learned;
		upd       = learn_act & valid_q & (addr_q == req_in.src_mac);
		ins       = learn_act & ~valid_q;
		eff_valid = valid_q | ins;
		eff_addr  = ins ? req_in.src_mac : addr_q;
		eff_port  = (upd | ins) ? req_in.ingress_port : port_q;
		hit_here  = req_in.valid & req_in.long_enough & ~req_in.hit & eff_valid
			& (eff_addr == req_in.dst_mac);

		req_nxt         = req_in;
		req_nxt.learned = req_in.learned | upd | ins;
		if (upd) begin
			req_nxt.status = LRN_UPDATED;
		end else if (ins) begin
			req_nxt.status = LRN_INSERTED;
		end
		if (hit_here) begin
			req_nxt.hit      = 1'b1;
			req_nxt.hit_port = eff_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			req_s1  <= '0;
		end else if (advance) begin
			if (ins) begin
				valid_q <= 1'b1;
			end
			req_s1 <= req_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (upd || ins)) begin
			addr_q <= req_in.src_mac;
			port_q <= req_in.ingress_port;
		end
	end

	assign req_out = req_s1;

endmodule

// File: hdl/mlf_out.sv
// Result stage: turns the request leaving the last cell into the egress mask,
// flood flag and learn status, held in the output register. Uses mlf_pkg.
`timescale 1ns / 1ps

module mlf_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  mlf_pkg::req_t             req_in,
	input  logic [mlf_pkg::CFG_W-1:0] ports_in_use,
	output logic                      out_valid,
	output logic [mlf_pkg::MASK_W-1:0] egress_mask,
	output logic                      flooded,
	output logic [1:0]                learn_status
);
	import mlf_pkg::*;

	logic [CFG_W-1:0]  n_ports;
	logic [MASK_W-1:0] act_mask;
	logic [MASK_W-1:0] mask_nxt;
	lrn_status_t       status_nxt;

	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic              flooded_q;
	lrn_status_t       status_q;

	always_comb begin
		n_ports  = (ports_in_use > PORTS_LIMIT) ? PORTS_LIMIT : ports_in_use;
		act_mask = MASK_W'(((MASK_W+1)'(1) << n_ports) - (MASK_W+1)'(1));
		if (req_in.hit) begin
			mask_nxt = (MASK_W'(1) << req_in.hit_port) & act_mask;
		end else begin
			mask_nxt = act_mask & ~(MASK_W'(1) << req_in.ingress_port);
		end
		// A unicast source that found neither its entry nor a free cell is reported as LRN_FULL.
		if (req_in.long_enough && !req_in.src_mac[GROUP_BIT] && !req_in.learned) begin
			status_nxt = LRN_FULL;
		end else begin
			status_nxt = req_in.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= req_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q    <= mask_nxt;
			flooded_q <= ~req_in.hit;
			status_q  <= status_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign egress_mask  = mask_q;
	assign flooded      = flooded_q;
	assign learn_status = status_q;

endmodule

// File: hdl/ethernet_mac_learning_forwarder_unit.sv
// Pipeline: the accepting edge loads the first cell's register, each further cell adds its
// own register, and the result register follows the last cell.
// Throughput: one request per cycle; the cell chain and the result stage
// advance together and stall together when the result is not taken.
// Reset: the table empties (all cell valid bits clear) and ports_in_use is 8.
// Depends on mlf_pkg, mlf_cell and mlf_out.
`timescale 1ns / 1ps

module ethernet_mac_learning_forwarder_unit #(
	parameter int TABLE_ENTRIES = mlf_pkg::TABLE_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mlf_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mlf_pkg::MAC_W-1:0]  src_mac,
	input  logic [mlf_pkg::MAC_W-1:0]  dst_mac,
	input  logic [mlf_pkg::PORT_W-1:0] ingress_port,
	input  logic                       long_enough,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mlf_pkg::MASK_W-1:0] egress_mask,
	output logic                       flooded,
	output logic [1:0]                 learn_status
);
	import mlf_pkg::*;

	logic             advance;
	logic [CFG_W-1:0] ports_in_use_q;
	req_t             chain [TABLE_ENTRIES+1];

	assign advance  = ~out_valid | out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_in_use_q <= PORTS_RESET;
		end else if (cfg_wr_en) begin
			ports_in_use_q <= cfg_wr_data;
		end
	end

	always_comb begin
		chain[0]              = '0;
		chain[0].valid        = in_valid;
		chain[0].src_mac      = src_mac;
		chain[0].dst_mac      = dst_mac;
		chain[0].ingress_port = ingress_port;
		chain[0].long_enough  = long_enough;
		chain[0].status       = LRN_NONE;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		mlf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.req_in  (chain[i]),
			.req_out (chain[i+1])
		);
	end

	mlf_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.req_in       (chain[TABLE_ENTRIES]),
		.ports_in_use (ports_in_use_q),
		.out_valid    (out_valid),
		.egress_mask  (egress_mask),
		.flooded      (flooded),
		.learn_status (learn_status)
	);

endmodule
